// File: rtl/core/websocket_frame_deframer_macros.svh
// Assertion macros for the WebSocket frame deframer.
// Used by websocket_frame_deframer.sv; expects aclk and aresetn in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wsd assertion failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wsd assertion failed");

`endif

// File: rtl/core/wsd_pkg.sv
// Types and codes shared by the WebSocket frame deframer.
// No dependencies.
`default_nettype none

package wsd_pkg;

    typedef enum logic [7:0] {
        PH_HDR0  = 8'b0000_0001,
        PH_HDR1  = 8'b0000_0010,
        PH_EXTHI = 8'b0000_0100,
        PH_EXTLO = 8'b0000_1000,
        PH_MASK  = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_SKIP  = 8'b0100_0000,
        PH_HALT  = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_EMPTY  = 3'd1,
        KIND_CLOSE  = 3'd2,
        KIND_PING   = 3'd3,
        KIND_LENERR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       is_binary;
        logic       message_end;
    } result_t;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

endpackage

`default_nettype wire

// File: rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer: takes one received byte per cycle while s_ready is high, gives
// at most one result per byte. Depends on wsd_pkg and websocket_frame_deframer_macros.svh.
//
// Each accepted byte advances the header/payload state machine in the same cycle, so the
// block sustains one byte per clock while s_ready is high. Each result is registered in
// the result register, or in the skid register if that one still waits. Two output slots
// (result and skid registers) let s_ready stay high while one result waits; s_ready drops
// only when both slots are full. Payload lengths are limited to 2^LEN_BITS-1; a longer or
// 64-bit length reports a length error and the block ignores later bytes until reset.
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer #(
    parameter int LEN_BITS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_data_byte,
    output logic            m_is_binary,
    output logic            m_message_end
);

    wsd_pkg::phase_t        phase_reg, phase_next;
    logic                   fin_reg, fin_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   masked_reg, masked_next;
    logic [LEN_BITS-1:0]    rem_reg, rem_next;
    logic [7:0]             ext_hi_reg, ext_hi_next;
    logic [7:0]             key_reg [4];
    logic [1:0]             midx_reg, midx_next;

    logic                   key_we;
    logic                   has_res;
    wsd_pkg::result_t       res;
    wsd_pkg::result_t       out_reg, skid_reg;
    logic                   out_valid_reg, skid_valid_reg;

    logic                   accept;
    logic                   pop;
    logic                   is_data_op;
    logic                   is_bin_op;
    logic [6:0]             len7;
    logic [15:0]            ext_len;
    logic [16:0]            ext_over;
    logic [LEN_BITS-1:0]    hdr_len;
    logic                   hdr_done;
    logic                   len_done;
    logic [7:0]             kb;

    assign accept     = s_valid && s_ready;
    assign pop        = out_valid_reg && m_ready;
    assign s_ready    = !skid_valid_reg;
    assign is_data_op = (opcode_reg == wsd_pkg::OP_TEXT) || (opcode_reg == wsd_pkg::OP_BINARY);
    assign is_bin_op  = (opcode_reg == wsd_pkg::OP_BINARY);
    assign len7       = s_rx_byte[6:0];
    assign ext_len    = {ext_hi_reg, s_rx_byte};
    assign ext_over   = {1'b0, ext_len} >> LEN_BITS;
    assign kb         = masked_reg ? key_reg[midx_reg] : 8'h00;

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        ext_hi_next = ext_hi_reg;
        midx_next   = midx_reg;
        key_we      = 1'b0;
        has_res     = 1'b0;
        hdr_len     = rem_reg;
        hdr_done    = 1'b0;
        len_done    = 1'b0;
        res         = '{kind: wsd_pkg::KIND_DATA, data_byte: 8'h00,
                        is_binary: 1'b0, message_end: 1'b0};

        case (phase_reg)
            wsd_pkg::PH_HDR0: begin
                fin_next    = s_rx_byte[7];
                opcode_next = s_rx_byte[3:0];
                phase_next  = wsd_pkg::PH_HDR1;
            end
            wsd_pkg::PH_HDR1: begin
                masked_next = s_rx_byte[7];
                if (len7 == wsd_pkg::LEN_CODE_EXT64) begin
                    phase_next = wsd_pkg::PH_HALT;
                    has_res    = 1'b1;
                    res.kind   = wsd_pkg::KIND_LENERR;
                end else if (len7 == wsd_pkg::LEN_CODE_EXT16) begin
                    phase_next = wsd_pkg::PH_EXTHI;
                end else begin
                    hdr_len  = LEN_BITS'(len7);
                    rem_next = hdr_len;
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_EXTHI: begin
                ext_hi_next = s_rx_byte;
                phase_next  = wsd_pkg::PH_EXTLO;
            end
            wsd_pkg::PH_EXTLO: begin
                if (ext_over != 17'd0) begin
                    phase_next = wsd_pkg::PH_HALT;
                    has_res    = 1'b1;
                    res.kind   = wsd_pkg::KIND_LENERR;
                end else begin
                    hdr_len  = ext_len[LEN_BITS-1:0];
                    rem_next = hdr_len;
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_MASK: begin
                key_we    = 1'b1;
                midx_next = midx_reg + 2'd1;
                hdr_done  = (midx_reg == 2'd3);
            end
            wsd_pkg::PH_DATA: begin
                midx_next       = midx_reg + 2'd1;
                rem_next        = rem_reg - LEN_BITS'(1);
                has_res         = 1'b1;
                res.kind        = wsd_pkg::KIND_DATA;
                res.data_byte   = s_rx_byte ^ kb;
                res.is_binary   = is_bin_op;
                res.message_end = (rem_reg == LEN_BITS'(1)) && fin_reg;
                if (rem_reg == LEN_BITS'(1)) begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            end
            wsd_pkg::PH_SKIP: begin
                rem_next = rem_reg - LEN_BITS'(1);
                if (rem_reg == LEN_BITS'(1)) begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            end
            default: begin
                phase_next = wsd_pkg::PH_HALT;
            end
        endcase

        if (len_done) begin
            if (masked_next) begin
                midx_next  = 2'd0;
                phase_next = wsd_pkg::PH_MASK;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            midx_next = 2'd0;
            if (is_data_op) begin
                if (hdr_len == '0) begin
                    phase_next = wsd_pkg::PH_HDR0;
                    if (fin_reg) begin
                        has_res         = 1'b1;
                        res.kind        = wsd_pkg::KIND_EMPTY;
                        res.is_binary   = is_bin_op;
                        res.message_end = 1'b1;
                    end
                end else begin
                    phase_next = wsd_pkg::PH_DATA;
                end
            end else begin
                phase_next = (hdr_len == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_SKIP;
                if (opcode_reg == wsd_pkg::OP_CLOSE) begin
                    has_res  = 1'b1;
                    res.kind = wsd_pkg::KIND_CLOSE;
                end else if (opcode_reg == wsd_pkg::OP_PING) begin
                    has_res  = 1'b1;
                    res.kind = wsd_pkg::KIND_PING;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsd_pkg::PH_HDR0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'h0;
            masked_reg <= 1'b0;
            rem_reg    <= '0;
            midx_reg   <= 2'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            midx_reg   <= midx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ext_hi_reg <= ext_hi_next;
            if (key_we) begin
                key_reg[midx_reg] <= s_rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && has_res) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept && has_res) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_data_byte   = out_reg.data_byte;
    assign m_is_binary   = out_reg.is_binary;
    assign m_message_end = out_reg.message_end;

    `WSD_ASSERT_NOW(a_skid_implies_out, skid_valid_reg, out_valid_reg)
    `WSD_ASSERT_NEXT(a_halt_sticks, phase_reg == wsd_pkg::PH_HALT,
                     phase_reg == wsd_pkg::PH_HALT)
    `WSD_ASSERT_NOW(a_ctrl_no_data, m_valid && (m_kind != wsd_pkg::KIND_DATA),
                    m_data_byte == 8'h00)
    `WSD_ASSERT_NOW(a_end_kind, m_valid && m_message_end,
                    (m_kind == wsd_pkg::KIND_DATA) || (m_kind == wsd_pkg::KIND_EMPTY))

endmodule

`default_nettype wire
